// ===== sv/aspit_pkg.sv =====
// shared types and constants of the angle-sum point-in-triangle test
`default_nettype none
package aspit_pkg;

  localparam int COORD_WIDTH     = 16;
  localparam int ANGLE_FRAC_BITS = 12;

  localparam int NUM_LANES = 3;

  // vector components and exact products
  localparam int DIFF_W = COORD_WIDTH + 1;
  localparam int NORM_W = 2 * DIFF_W;
  localparam int HALF_W = NORM_W / 2;
  localparam int PROD_W = 2 * NORM_W;

  // cosine search: quotient dot^2 * 2^28 / (|a|^2 |b|^2), then its root
  localparam int Q14        = 14;
  localparam int DIV_STEPS  = 2 * Q14 + 1;
  localparam int Q_W        = DIV_STEPS;
  localparam int SQRT_IN_W  = 2 * Q14 + 1;
  localparam int ROOT_IW    = SQRT_IN_W + 1;
  localparam int ROOT_W     = Q14 + 1;
  localparam int ROOT_STEPS = Q14 + 1;
  localparam int ONE_Q14    = 16384;

  // arccosine polynomial, Q16
  localparam int C3_Q16 = 1227;
  localparam int C2_Q16 = 4867;
  localparam int C1_Q16 = 13901;
  localparam int C0_Q16 = 102939;
  localparam int PI_Q16 = 205887;

  localparam int M1_W  = 26;
  localparam int R1_W  = 13;
  localparam int M2_W  = 28;
  localparam int R2_W  = 14;
  localparam int M3_W  = 29;
  localparam int R3_W  = 17;
  localparam int M4_W  = 32;
  localparam int ANGLE_W = 18;
  localparam int ASHIFT  = 16 - ANGLE_FRAC_BITS;

  localparam int SUM_W = ANGLE_W + 2;
  localparam int OUT_W = 16;
  localparam int THR_W = 16;
  localparam logic [THR_W-1:0] THR_RESET = THR_W'(25559);

  // register stages of one lane: products, norms, partial products, sums,
  // division, root, clamp, root, polynomial
  localparam int LANE_LAT = 4 + DIV_STEPS + ROOT_STEPS + 1 + ROOT_STEPS + 5;
  localparam int PIPE_LAT = LANE_LAT + 1;

  typedef logic [ANGLE_W-1:0] angle_t;

  typedef struct packed {
    logic neg;
    logic zero;
  } side_t;

endpackage
`default_nettype wire

// ===== sv/angle_sum_point_in_triangle_top.sv =====
// a result item passes the difference register, the lane stages and the output register of the merge
// throughput: one item per cycle while in_stall is low, three lanes in parallel, fixed-depth pipeline
// depth is set by the 29-step restoring divider and the two 15-step root units
// a held result freezes the pipeline only once its last stage is occupied
// reset (synchronous, rst_n low) empties the pipeline and sets the threshold to 25559
`default_nettype none
module angle_sum_point_in_triangle_top (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [aspit_pkg::COORD_WIDTH-1:0] in_vertex_a_x,
  input  logic signed [aspit_pkg::COORD_WIDTH-1:0] in_vertex_a_y,
  input  logic signed [aspit_pkg::COORD_WIDTH-1:0] in_vertex_b_x,
  input  logic signed [aspit_pkg::COORD_WIDTH-1:0] in_vertex_b_y,
  input  logic signed [aspit_pkg::COORD_WIDTH-1:0] in_vertex_c_x,
  input  logic signed [aspit_pkg::COORD_WIDTH-1:0] in_vertex_c_y,
  input  logic signed [aspit_pkg::COORD_WIDTH-1:0] in_query_x,
  input  logic signed [aspit_pkg::COORD_WIDTH-1:0] in_query_y,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic                                  out_inside_res,
  output logic [aspit_pkg::OUT_W-1:0]           out_angle_sum,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [aspit_pkg::THR_W-1:0]           cfg_inside_threshold
);
  import aspit_pkg::*;

  logic                     en;
  logic [PIPE_LAT-1:0]      vld_r;
  logic [THR_W-1:0]         thr_r;
  logic signed [DIFF_W-1:0] ax_r, ay_r, bx_r, by_r, cx_r, cy_r;
  angle_t                   lane_angle [NUM_LANES];

  assign in_stall  = !en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
    end else if (cfg_valid) begin
      thr_r <= cfg_inside_threshold;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[PIPE_LAT-2:0], in_valid};
    end
  end

  // vectors from the query point to each vertex
  always_ff @(posedge clk) begin
    if (en) begin
      ax_r <= $signed({in_vertex_a_x[COORD_WIDTH-1], in_vertex_a_x})
            - $signed({in_query_x[COORD_WIDTH-1], in_query_x});
      ay_r <= $signed({in_vertex_a_y[COORD_WIDTH-1], in_vertex_a_y})
            - $signed({in_query_y[COORD_WIDTH-1], in_query_y});
      bx_r <= $signed({in_vertex_b_x[COORD_WIDTH-1], in_vertex_b_x})
            - $signed({in_query_x[COORD_WIDTH-1], in_query_x});
      by_r <= $signed({in_vertex_b_y[COORD_WIDTH-1], in_vertex_b_y})
            - $signed({in_query_y[COORD_WIDTH-1], in_query_y});
      cx_r <= $signed({in_vertex_c_x[COORD_WIDTH-1], in_vertex_c_x})
            - $signed({in_query_x[COORD_WIDTH-1], in_query_x});
      cy_r <= $signed({in_vertex_c_y[COORD_WIDTH-1], in_vertex_c_y})
            - $signed({in_query_y[COORD_WIDTH-1], in_query_y});
    end
  end

  aspit_lane u_lane_ab (
    .clk (clk), .en (en),
    .a_x (ax_r), .a_y (ay_r), .b_x (bx_r), .b_y (by_r),
    .angle (lane_angle[0])
  );

  aspit_lane u_lane_bc (
    .clk (clk), .en (en),
    .a_x (bx_r), .a_y (by_r), .b_x (cx_r), .b_y (cy_r),
    .angle (lane_angle[1])
  );

  aspit_lane u_lane_ca (
    .clk (clk), .en (en),
    .a_x (cx_r), .a_y (cy_r), .b_x (ax_r), .b_y (ay_r),
    .angle (lane_angle[2])
  );

  aspit_merge u_merge (
    .clk            (clk),
    .rst_n          (rst_n),
    .last_valid     (vld_r[PIPE_LAT-1]),
    .lane_angle     (lane_angle),
    .threshold      (thr_r),
    .out_stall      (out_stall),
    .en             (en),
    .out_valid      (out_valid),
    .out_inside_res (out_inside_res),
    .out_angle_sum  (out_angle_sum)
  );

endmodule
`default_nettype wire

// ===== sv/aspit_isqrt.sv =====
// pipelined integer square root, one result bit per stage
`default_nettype none
module aspit_isqrt (
  input  logic                           clk,
  input  logic                           en,
  input  logic [aspit_pkg::SQRT_IN_W-1:0] rad,
  output logic [aspit_pkg::ROOT_W-1:0]    root
);
  import aspit_pkg::*;

  logic [SQRT_IN_W-1:0] rem_r [ROOT_STEPS];
  logic [ROOT_IW-1:0]   res_r [ROOT_STEPS];

  for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_step
    localparam logic [ROOT_IW-1:0] BIT = ROOT_IW'(1) << (2 * (ROOT_STEPS - 1 - k));
    logic [SQRT_IN_W-1:0] rem_in;
    logic [ROOT_IW-1:0]   res_in;
    logic [ROOT_IW-1:0]   trial;

    if (k == 0) begin : g_first
      assign rem_in = rad;
      assign res_in = '0;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign res_in = res_r[k-1];
    end

    assign trial = res_in + BIT;

    always_ff @(posedge clk) begin
      if (en) begin
        if ({1'b0, rem_in} >= trial) begin
          rem_r[k] <= rem_in - SQRT_IN_W'(trial);
          res_r[k] <= (res_in >> 1) + BIT;
        end else begin
          rem_r[k] <= rem_in;
          res_r[k] <= res_in >> 1;
        end
      end
    end
  end

  assign root = ROOT_W'(res_r[ROOT_STEPS-1]);

endmodule
`default_nettype wire

// ===== sv/aspit_lane.sv =====
// one lane: angle between two vectors, cosine by exact division and root
`default_nettype none
module aspit_lane (
  input  logic                               clk,
  input  logic                               en,
  input  logic signed [aspit_pkg::DIFF_W-1:0] a_x,
  input  logic signed [aspit_pkg::DIFF_W-1:0] a_y,
  input  logic signed [aspit_pkg::DIFF_W-1:0] b_x,
  input  logic signed [aspit_pkg::DIFF_W-1:0] b_y,
  output aspit_pkg::angle_t                   angle
);
  import aspit_pkg::*;

  // products
  logic signed [NORM_W-1:0] pxx_r, pyy_r, sax_r, say_r, sbx_r, sby_r;
  // norms and dot magnitude
  logic [NORM_W-1:0] dm_r, na_r, nb_r;
  side_t             l2_side_r, l3_side_r, l4_side_r;
  logic signed [NORM_W:0] dot_c;
  logic              dneg_c;
  // partial products
  logic [NORM_W-1:0] d_hh_r, d_hl_r, d_ll_r, p_hh_r, p_hl_r, p_lh_r, p_ll_r;
  logic [PROD_W-1:0] dsq_r, den_r;
  // division
  logic [PROD_W-1:0] dv_rem_r [DIV_STEPS];
  logic [PROD_W-1:0] dv_den_r [DIV_STEPS];
  logic [Q_W-1:0]    dv_quo_r [DIV_STEPS];
  side_t             dv_side_r [DIV_STEPS];
  // roots
  logic [ROOT_W-1:0] root1, root2;
  side_t             sd_r [ROOT_STEPS];
  logic [ROOT_W-1:0] x_c, x_r;
  logic              xneg_r;
  logic [ROOT_W-1:0] xd_r [ROOT_STEPS];
  logic              negd_r [ROOT_STEPS];
  // polynomial
  logic [M1_W-1:0]   m1_r;
  logic [M2_W-1:0]   m2_r;
  logic [M3_W-1:0]   m3_r;
  logic [M4_W-1:0]   m4_r;
  logic [ROOT_W-1:0] p1_x_r, p2_x_r, p1_s_r, p2_s_r, p3_s_r;
  logic              p1_neg_r, p2_neg_r, p3_neg_r, p4_neg_r;
  logic [R1_W-1:0]   r1_c;
  logic [R2_W-1:0]   r2_c;
  logic [R3_W-1:0]   r3_c;
  logic [ANGLE_W-1:0] a_c, ang_c, angle_r;

  always_ff @(posedge clk) begin
    if (en) begin
      pxx_r <= a_x * b_x;
      pyy_r <= a_y * b_y;
      sax_r <= a_x * a_x;
      say_r <= a_y * a_y;
      sbx_r <= b_x * b_x;
      sby_r <= b_y * b_y;
    end
  end

  assign dot_c  = $signed({pxx_r[NORM_W-1], pxx_r}) + $signed({pyy_r[NORM_W-1], pyy_r});
  assign dneg_c = dot_c[NORM_W];

  always_ff @(posedge clk) begin
    if (en) begin
      dm_r <= dneg_c ? NORM_W'(-dot_c) : NORM_W'(dot_c);
      na_r <= $unsigned(sax_r) + $unsigned(say_r);
      nb_r <= $unsigned(sbx_r) + $unsigned(sby_r);
      l2_side_r.neg  <= dneg_c;
      l2_side_r.zero <= ((sax_r == '0) && (say_r == '0)) || ((sbx_r == '0) && (sby_r == '0));
    end
  end

  // wide square and product split into halves
  always_ff @(posedge clk) begin
    if (en) begin
      d_hh_r <= dm_r[NORM_W-1:HALF_W] * dm_r[NORM_W-1:HALF_W];
      d_hl_r <= dm_r[NORM_W-1:HALF_W] * dm_r[HALF_W-1:0];
      d_ll_r <= dm_r[HALF_W-1:0] * dm_r[HALF_W-1:0];
      p_hh_r <= na_r[NORM_W-1:HALF_W] * nb_r[NORM_W-1:HALF_W];
      p_hl_r <= na_r[NORM_W-1:HALF_W] * nb_r[HALF_W-1:0];
      p_lh_r <= na_r[HALF_W-1:0] * nb_r[NORM_W-1:HALF_W];
      p_ll_r <= na_r[HALF_W-1:0] * nb_r[HALF_W-1:0];
      l3_side_r <= l2_side_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dsq_r <= (PROD_W'(d_hh_r) << NORM_W) + (PROD_W'(d_hl_r) << (HALF_W + 1))
             + PROD_W'(d_ll_r);
      den_r <= (PROD_W'(p_hh_r) << NORM_W)
             + ((PROD_W'(p_hl_r) + PROD_W'(p_lh_r)) << HALF_W) + PROD_W'(p_ll_r);
      l4_side_r <= l3_side_r;
    end
  end

  // restoring division, first step takes the integer bit
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    logic [PROD_W-1:0] rem_in, den_in;
    logic [Q_W-1:0]    quo_in;
    side_t             side_in;

    if (k == 0) begin : g_first
      assign rem_in  = dsq_r;
      assign den_in  = den_r;
      assign quo_in  = '0;
      assign side_in = l4_side_r;
    end else begin : g_next
      assign rem_in  = {dv_rem_r[k-1][PROD_W-2:0], 1'b0};
      assign den_in  = dv_den_r[k-1];
      assign quo_in  = dv_quo_r[k-1];
      assign side_in = dv_side_r[k-1];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (rem_in >= den_in) begin
          dv_rem_r[k] <= rem_in - den_in;
          dv_quo_r[k] <= {quo_in[Q_W-2:0], 1'b1};
        end else begin
          dv_rem_r[k] <= rem_in;
          dv_quo_r[k] <= {quo_in[Q_W-2:0], 1'b0};
        end
        dv_den_r[k]  <= den_in;
        dv_side_r[k] <= side_in;
      end
    end
  end

  aspit_isqrt u_cos_root (
    .clk  (clk),
    .en   (en),
    .rad  (SQRT_IN_W'(dv_quo_r[DIV_STEPS-1])),
    .root (root1)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      sd_r[0] <= dv_side_r[DIV_STEPS-1];
      for (int k = 1; k < ROOT_STEPS; k++) sd_r[k] <= sd_r[k-1];
    end
  end

  // zero length vector gives cosine 0
  always_comb begin
    if (sd_r[ROOT_STEPS-1].zero) x_c = '0;
    else if (root1 > ROOT_W'(ONE_Q14)) x_c = ROOT_W'(ONE_Q14);
    else x_c = root1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r    <= x_c;
      xneg_r <= sd_r[ROOT_STEPS-1].neg && !sd_r[ROOT_STEPS-1].zero && (x_c != '0);
    end
  end

  aspit_isqrt u_sin_root (
    .clk  (clk),
    .en   (en),
    .rad  (SQRT_IN_W'({ROOT_W'(ONE_Q14) - x_r, Q14'(0)})),
    .root (root2)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      xd_r[0]   <= x_r;
      negd_r[0] <= xneg_r;
      for (int k = 1; k < ROOT_STEPS; k++) begin
        xd_r[k]   <= xd_r[k-1];
        negd_r[k] <= negd_r[k-1];
      end
    end
  end

  assign r1_c = R1_W'(32'(C2_Q16) - 32'(m1_r >> Q14));
  assign r2_c = R2_W'(32'(C1_Q16) - 32'(m2_r >> Q14));
  assign r3_c = R3_W'(32'(C0_Q16) - 32'(m3_r >> Q14));
  assign a_c  = ANGLE_W'(m4_r >> Q14);
  assign ang_c = p4_neg_r ? ANGLE_W'(PI_Q16) - a_c : a_c;

  always_ff @(posedge clk) begin
    if (en) begin
      m1_r     <= M1_W'(R1_W'(C3_Q16) * xd_r[ROOT_STEPS-1]);
      p1_x_r   <= xd_r[ROOT_STEPS-1];
      p1_s_r   <= root2;
      p1_neg_r <= negd_r[ROOT_STEPS-1];

      m2_r     <= M2_W'(r1_c * p1_x_r);
      p2_x_r   <= p1_x_r;
      p2_s_r   <= p1_s_r;
      p2_neg_r <= p1_neg_r;

      m3_r     <= M3_W'(r2_c * p2_x_r);
      p3_s_r   <= p2_s_r;
      p3_neg_r <= p2_neg_r;

      m4_r     <= M4_W'(r3_c * p3_s_r);
      p4_neg_r <= p3_neg_r;

      angle_r  <= ang_c >> ASHIFT;
    end
  end

  assign angle = angle_r;

endmodule
`default_nettype wire

// ===== sv/aspit_merge.sv =====
// sums the lane angles, compares against the threshold, holds the result item
`default_nettype none
module aspit_merge (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          last_valid,
  input  aspit_pkg::angle_t             lane_angle [aspit_pkg::NUM_LANES],
  input  logic [aspit_pkg::THR_W-1:0]   threshold,
  input  logic                          out_stall,
  output logic                          en,
  output logic                          out_valid,
  output logic                          out_inside_res,
  output logic [aspit_pkg::OUT_W-1:0]   out_angle_sum
);
  import aspit_pkg::*;

  localparam logic [SUM_W-1:0] SUM_MAX = SUM_W'(3 * (PI_Q16 >> ASHIFT));

  logic              out_free;
  logic [SUM_W-1:0]  sum_c;
  logic [OUT_W-1:0]  sat_c;
  logic              out_valid_r;
  logic              inside_r;
  logic [OUT_W-1:0]  sum_r;

  assign out_free = !out_valid_r || !out_stall;
  assign en       = out_free || !last_valid;

  always_comb begin
    sum_c = '0;
    for (int i = 0; i < NUM_LANES; i++) sum_c = sum_c + SUM_W'(lane_angle[i]);
  end

  assign sat_c = (sum_c > SUM_W'({OUT_W{1'b1}})) ? {OUT_W{1'b1}} : OUT_W'(sum_c);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= last_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && last_valid) begin
      sum_r    <= sat_c;
      inside_r <= sat_c > threshold;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_inside_res = inside_r;
  assign out_angle_sum  = sum_r;

  // an item leaving the pipeline always lands in the output register
  a_load: assert property (@(posedge clk) disable iff (!rst_n)
    $past(en) && $past(last_valid) |-> out_valid_r)
    else $error("item dropped at output register");

  // pipeline only freezes behind a held result
  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    !en |-> out_valid_r && out_stall && last_valid)
    else $error("pipeline stalled without a waiting result");

  // three angles of at most pi each
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (SUM_W'(sum_r) <= SUM_MAX) || (sum_r == {OUT_W{1'b1}}))
    else $error("angle sum out of range");

endmodule
`default_nettype wire
